[rtl/swrm_pkg.sv]
// ----------------------------------------------------------------------------
// swrm_pkg - shared types and constants of the sliding window rate meter
// Field widths, register indexes, register reset values and the config type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swrm_pkg;

	// field widths
	localparam int CMD_W     = 1;
	localparam int TIME_W    = 32;
	localparam int BYTES_W   = 24;
	localparam int RATE_W    = 40;
	localparam int WBYTES_W  = 30;
	localparam int ENTRIES_W = 7;

	// configuration port
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_W-1:0]     cfg_val_t;

	localparam cfg_idx_t REG_WINDOW_MS    = 2'd0;
	localparam cfg_idx_t REG_NEW_ENTRY_GAP = 2'd1;
	localparam cfg_idx_t REG_MIN_SLOT_AGE = 2'd2;

	localparam cfg_val_t WINDOW_MS_RST    = 20'd10000;
	localparam cfg_val_t NEW_ENTRY_GAP_RST = 20'd1000;
	localparam cfg_val_t MIN_SLOT_AGE_RST = 20'd2000;

	// command codes
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b0;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 1'b1;

	// ms to s scaling, and the bits it adds to a product
	localparam int MS_PER_S   = 1000;
	localparam int MS_PER_S_W = 10;

	// saturation limits of the result fields
	localparam logic [RATE_W-1:0]   RATE_MAX   = {RATE_W{1'b1}};
	localparam logic [WBYTES_W-1:0] WBYTES_MAX = {WBYTES_W{1'b1}};

	typedef logic [TIME_W-1:0]    time_t;
	typedef logic [BYTES_W-1:0]   bytes_t;
	typedef logic [RATE_W-1:0]    rate_t;
	typedef logic [WBYTES_W-1:0]  wbytes_t;
	typedef logic [ENTRIES_W-1:0] entries_t;

	typedef struct packed {
		cfg_val_t window_ms;
		cfg_val_t new_entry_gap_ms;
		cfg_val_t min_slot_age_ms;
	} cfg_t;

	// divider handshake with the sequencer
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[rtl/swrm_if.sv]
// ----------------------------------------------------------------------------
// swrm_if - valid/ready channels of the sliding window rate meter
// Sample channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface swrm_in_if;
	import swrm_pkg::*;

	logic   valid;
	logic   ready;
	logic   cmd;
	time_t  now_ms;
	bytes_t bytes_sent;
	time_t  slot_age_ms;

	modport source (output valid, cmd, now_ms, bytes_sent, slot_age_ms, input ready);
	modport sink   (input valid, cmd, now_ms, bytes_sent, slot_age_ms, output ready);
endinterface

interface swrm_out_if;
	import swrm_pkg::*;

	logic     valid;
	logic     ready;
	rate_t    rate_bytes_per_s;
	wbytes_t  window_bytes;
	entries_t entries_held;

	modport source (output valid, rate_bytes_per_s, window_bytes, entries_held, input ready);
	modport sink   (input valid, rate_bytes_per_s, window_bytes, entries_held, output ready);
endinterface

[rtl/swrm_ram.sv]
// ----------------------------------------------------------------------------
// swrm_ram - generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swrm_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/swrm_div.sv]
// ----------------------------------------------------------------------------
// swrm_div - restoring radix-2 divider
// Unsigned NUM_W by 32 bit divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swrm_div #(
	parameter int NUM_W = 41
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  swrm_pkg::div_req_t     req,
	input  logic [NUM_W-1:0]       num,
	input  swrm_pkg::time_t        den,
	output swrm_pkg::div_stat_t    stat,
	output logic [NUM_W-1:0]       quot
);
	import swrm_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;   // dividend bits shift out, quotient bits shift in
	time_t            rem_q;
	time_t            den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [TIME_W:0]  trial;
	logic             qbit;

	// one trial subtraction per cycle
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		qbit  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// last quotient bit lands on the final busy cycle
			done_q <= busy_q && !req.start && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], qbit};
			rem_q <= qbit ? TIME_W'(trial - {1'b0, den_q}) : trial[TIME_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = num_q;

endmodule

[rtl/sliding_window_rate_meter_top.sv]
// ----------------------------------------------------------------------------
// sliding_window_rate_meter_top - windowed byte rate over a history FIFO
// A clear word goes from idle straight to the finish state, which loads the
//   output register once it is free; a sample goes through check, evict (full
//   history only), scan read (skipped when no entry is recorded), scan, then
//   start and divide for a rate, and finish. The bit-serial divider dominates.
// Throughput: one word at a time; the next sample is taken once the result
//   is in the output register. Reset empties the FIFO at once (no clear pass).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_rate_meter_top #(
	parameter int HISTORY_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	swrm_in_if.sink             in_ch,
	swrm_out_if.source          out_ch,
	input  logic                cfg_we,
	input  swrm_pkg::cfg_idx_t  cfg_idx,
	input  swrm_pkg::cfg_val_t  cfg_wdata
);
	import swrm_pkg::*;

	localparam int PTR_W     = $clog2(HISTORY_DEPTH);
	localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_RAW_W = BYTES_W + CNT_W;
	localparam int SUM_W     = (SUM_RAW_W > WBYTES_W) ? SUM_RAW_W : WBYTES_W + 1;
	localparam int NUM_W     = SUM_W + MS_PER_S_W;
	localparam int CNTX_W    = (CNT_W > ENTRIES_W) ? CNT_W : ENTRIES_W;
	localparam int ENT_W     = BYTES_W + TIME_W;

	// sequencer states
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_CHK     = 3'd1;
	localparam logic [2:0] S_EVICT   = 3'd2;
	localparam logic [2:0] S_SCAN_RD = 3'd3;
	localparam logic [2:0] S_SCAN    = 3'd4;
	localparam logic [2:0] S_START   = 3'd5;
	localparam logic [2:0] S_DIV     = 3'd6;
	localparam logic [2:0] S_FIN     = 3'd7;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] prev_ptr(input logic [PTR_W-1:0] p);
		prev_ptr = (p == '0) ? PTR_W'(HISTORY_DEPTH - 1) : p - 1'b1;
	endfunction

	cfg_t             cfg_q;
	logic [2:0]       state_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	time_t            now_q;
	bytes_t           bytes_q;
	logic             slot_ok_q;
	time_t            age_q;
	rate_t            rate_q;

	logic             out_valid_q;
	rate_t            out_rate_q;
	wbytes_t          out_wbytes_q;
	entries_t         out_entries_q;

	logic             in_acc;
	logic             out_free;
	logic             ram_we;
	logic             ram_re;
	logic [PTR_W-1:0] ram_raddr;
	logic [ENT_W-1:0] ram_rdata;
	bytes_t           rd_bytes;
	time_t            rd_time;
	time_t            rd_age;
	logic             push;
	logic             full;
	logic             drop;

	div_req_t         div_req;
	div_stat_t        div_stat;
	logic [NUM_W-1:0] div_num;
	logic [NUM_W-1:0] div_quot;
	logic [CNTX_W-1:0] count_x;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_ms        <= WINDOW_MS_RST;
			cfg_q.new_entry_gap_ms <= NEW_ENTRY_GAP_RST;
			cfg_q.min_slot_age_ms  <= MIN_SLOT_AGE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WINDOW_MS:     cfg_q.window_ms        <= cfg_wdata;
				REG_NEW_ENTRY_GAP: cfg_q.new_entry_gap_ms <= cfg_wdata;
				REG_MIN_SLOT_AGE:  cfg_q.min_slot_age_ms  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	// history entry read back: {bytes, time}
	assign rd_bytes = ram_rdata[ENT_W-1:TIME_W];
	assign rd_time  = ram_rdata[TIME_W-1:0];
	assign rd_age   = now_q - rd_time;

	assign full = (count_q == CNT_W'(HISTORY_DEPTH));
	assign push = (bytes_q != '0) || (count_q == '0) ||
		(rd_age > TIME_W'(cfg_q.new_entry_gap_ms));
	assign drop = (rd_age > TIME_W'(cfg_q.window_ms));

	// memory read address per state
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = head_q;
		unique case (state_q)
			S_IDLE: begin
				ram_re    = in_acc;
				ram_raddr = prev_ptr(tail_q);
			end
			S_CHK: begin
				ram_re = !push || full;
			end
			S_SCAN_RD: begin
				ram_re = 1'b1;
			end
			S_SCAN: begin
				ram_re    = drop;
				ram_raddr = next_ptr(head_q);
			end
			default: ;
		endcase
	end

	assign ram_we = ((state_q == S_CHK) && push && !full) || (state_q == S_EVICT);

	swrm_ram #(
		.WIDTH (ENT_W),
		.DEPTH (HISTORY_DEPTH),
		.AW    (PTR_W)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata ({bytes_q, now_q}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sum * 1000 feeds the divider input register directly
	assign div_req.start = (state_q == S_START);
	assign div_num       = NUM_W'(sum_q) * NUM_W'(MS_PER_S);

	swrm_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num),
		.den    (age_q),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	// sequencer and FIFO bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_ch.cmd == CMD_CLEAR) begin
							head_q  <= '0;
							tail_q  <= '0;
							count_q <= '0;
							sum_q   <= '0;
							state_q <= S_FIN;
						end else begin
							state_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					priority if (!push) begin
						state_q <= S_SCAN;
					end else if (full) begin
						state_q <= S_EVICT;
					end else begin
						tail_q  <= next_ptr(tail_q);
						count_q <= count_q + 1'b1;
						sum_q   <= sum_q + SUM_W'(bytes_q);
						state_q <= S_SCAN_RD;
					end
				end
				S_EVICT: begin
					// oldest out, new one in: count is unchanged
					sum_q   <= sum_q - SUM_W'(rd_bytes) + SUM_W'(bytes_q);
					head_q  <= next_ptr(head_q);
					tail_q  <= next_ptr(tail_q);
					state_q <= S_SCAN_RD;
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (drop) begin
						sum_q   <= sum_q - SUM_W'(rd_bytes);
						head_q  <= next_ptr(head_q);
						count_q <= count_q - 1'b1;
						if (count_q == CNT_W'(1)) begin
							state_q <= S_FIN;
						end
					end else if ((rd_age != '0) && slot_ok_q) begin
						state_q <= S_START;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-word payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q     <= in_ch.now_ms;
			bytes_q   <= in_ch.bytes_sent;
			slot_ok_q <= (in_ch.slot_age_ms > TIME_W'(cfg_q.min_slot_age_ms));
			rate_q    <= '0;
		end
		if (state_q == S_SCAN) begin
			age_q <= rd_age;
		end
		if ((state_q == S_DIV) && div_stat.done) begin
			rate_q <= (div_quot > NUM_W'(RATE_MAX)) ? RATE_MAX : div_quot[RATE_W-1:0];
		end
	end

	// output register
	assign count_x = CNTX_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && out_free) begin
			out_rate_q    <= rate_q;
			out_wbytes_q  <= (sum_q > SUM_W'(WBYTES_MAX)) ? WBYTES_MAX : sum_q[WBYTES_W-1:0];
			out_entries_q <= count_x[ENTRIES_W-1:0];
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.rate_bytes_per_s = out_rate_q;
	assign out_ch.window_bytes     = out_wbytes_q;
	assign out_ch.entries_held     = out_entries_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HISTORY_DEPTH))
		else $error("history count above depth");

	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == tail_q) == ((count_q == '0) || (count_q == CNT_W'(HISTORY_DEPTH))))
		else $error("head/tail pointers disagree with count");

	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (sum_q == '0))
		else $error("nonzero sum with empty history");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV))
		else $error("divider finished outside divide state");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_stat.busy || div_stat.done))
		else $error("divide state with divider idle");

endmodule
